// ----- rtl/assert_macros.svh -----
// Assertion shorthands for the downscaler RTL.
// Every macro samples on posedge clk and is quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every sampled edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/nds_pkg.sv -----
// Shared types and constants of the 2-bit pixel downscaler.
// No dependencies; compiled first.
package nds_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 3072;

    localparam int DIM_W     = 12;
    localparam int LEVEL_W   = 2;
    localparam int BYTE_W    = 8;
    localparam int TROW_W    = 12;
    localparam int BIDX_W    = 9;
    localparam int CFG_IDX_W = 3;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int XW        = $clog2(MAX_WIDTH + 1);
    localparam int COL_ACC_W = $clog2(MAX_WIDTH * MAX_WIDTH + 1);
    localparam int ROW_ACC_W = $clog2(MAX_HEIGHT * MAX_HEIGHT + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_TARGET_WIDTH  = 3'd2,
        CFG_TARGET_HEIGHT = 3'd3,
        CFG_TOP_DOWN      = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_MUL,
        ST_LOAD,
        ST_RUN
    } nds_state_t;

    typedef struct packed {
        logic [DIM_W-1:0] sw;
        logic [DIM_W-1:0] sh;
        logic [DIM_W-1:0] tw;
        logic [DIM_W-1:0] th;
        logic             top_down;
    } nds_sizes_t;

    typedef struct packed {
        logic restart;
        logic mul_en;
        logic load;
        logic step;
    } nds_cmd_t;

    typedef struct packed {
        logic out_full;
    } nds_stat_t;

    // Clamp a size to 1..hi.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

// ----- rtl/nds_if.sv -----
// Valid/ready channel interfaces: source pixels in, packed bytes out.
// Depends on nds_pkg for field widths.
interface nds_pix_if;
    logic                        valid;
    logic                        ready;
    logic [nds_pkg::LEVEL_W-1:0] gray_level;

    modport source (output valid, output gray_level, input ready);
    modport sink   (input valid, input gray_level, output ready);
endinterface

interface nds_byte_if;
    logic                       valid;
    logic                       ready;
    logic [nds_pkg::BYTE_W-1:0] packed_byte;
    logic [nds_pkg::TROW_W-1:0] target_row;
    logic [nds_pkg::BIDX_W-1:0] byte_index;
    logic                       row_done;

    modport source (output valid, output packed_byte, output target_row,
                    output byte_index, output row_done, input ready);
    modport sink   (input valid, input packed_byte, input target_row,
                    input byte_index, input row_done, output ready);
endinterface

// ----- rtl/nds_ctrl.sv -----
// Controller of the downscaler: frame setup sequence and input handshake.
// Depends on nds_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nds_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_hit,
    input  logic              in_valid,
    input  logic              out_ready,
    input  nds_pkg::nds_stat_t stat,
    output logic              in_ready,
    output nds_pkg::nds_cmd_t cmd
);
    import nds_pkg::*;

    nds_state_t state_reg;
    nds_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_MUL;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        if (cfg_hit)
            state_next = ST_MUL;
        else
        begin
            case (state_reg)
                ST_MUL:  state_next = ST_LOAD;
                ST_LOAD: state_next = ST_RUN;
                ST_RUN:  state_next = ST_RUN;
                default: state_next = ST_MUL;
            endcase
        end
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.restart = cfg_hit;
        cmd.mul_en  = 1'b0;
        cmd.load    = 1'b0;
        case (state_reg)
            ST_MUL:  cmd.mul_en = !cfg_hit;
            ST_LOAD: cmd.load   = !cfg_hit;
            ST_RUN:  in_ready   = !stat.out_full || out_ready;
            default: in_ready   = 1'b0;
        endcase
        cmd.step = in_valid && in_ready;
    end

    // a register write must hold off pixels until the frame is set up again
    `ASSERT_NEXT(a_cfg_blocks_input, cfg_hit, !in_ready,
                 "pixel accepted right after a register write")

endmodule

// ----- rtl/nds_dp.sv -----
// Datapath of the downscaler: position counters, row/column keep accumulators,
// byte packing and the output word register. Depends on nds_pkg, assert_macros.svh.
`include "assert_macros.svh"

module nds_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  nds_pkg::nds_sizes_t         sizes,
    input  nds_pkg::nds_cmd_t           cmd,
    output nds_pkg::nds_stat_t          stat,
    input  logic [nds_pkg::LEVEL_W-1:0] gray_level,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [nds_pkg::BYTE_W-1:0]  packed_byte,
    output logic [nds_pkg::TROW_W-1:0]  target_row,
    output logic [nds_pkg::BIDX_W-1:0]  byte_index,
    output logic                        row_done
);
    import nds_pkg::*;

    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     prow_reg, prow_next;
    logic [XW-1:0]        x_reg, x_next;
    logic [COL_ACC_W-1:0] acol_reg, acol_next;
    logic [COL_ACC_W-1:0] bcol_reg, bcol_next;
    logic [ROW_ACC_W-1:0] ay_reg, ay_next;
    logic [ROW_ACC_W-1:0] by_reg, by_next;
    logic [ROW_ACC_W-1:0] prod_reg, prod_next;
    logic [ROW_W-1:0]     y_reg, y_next;
    logic [ROW_W-1:0]     cur_row_reg, cur_row_next;
    logic                 row_kept_reg, row_kept_next;
    logic [BYTE_W-1:0]    pack_reg, pack_next;

    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic [TROW_W-1:0]    out_row_reg;
    logic [BIDX_W-1:0]    out_bidx_reg;
    logic                 out_done_reg;

    logic [DIM_W-1:0]     sw_m1, sh_m1, tw_m1;
    logic [ROW_ACC_W:0]   by_plus;
    logic [COL_ACC_W:0]   bcol_plus;
    logic                 row_start, row_hit, row_kept_now;
    logic [ROW_W-1:0]     row_now;
    logic                 col_hit, take, x_last, col_last, prow_last, emit;
    logic [1:0]           pos;
    logic [BYTE_W-1:0]    pack_ins;
    logic [ROW_ACC_W-1:0] ay_init, by_init;
    logic [ROW_W-1:0]     y_init;

    assign sw_m1 = sizes.sw - DIM_W'(1);
    assign sh_m1 = sizes.sh - DIM_W'(1);
    assign tw_m1 = sizes.tw - DIM_W'(1);

    // row keep: top first walks y up, bottom first walks y down
    assign by_plus   = {1'b0, by_reg} + (ROW_ACC_W + 1)'(sizes.th);
    assign row_start = (col_reg == '0);
    assign row_hit   = sizes.top_down ? ({1'b0, ay_reg} < by_plus) : (ay_reg >= by_reg);
    assign row_kept_now = row_start ? row_hit : row_kept_reg;
    assign row_now      = row_start ? y_reg : cur_row_reg;

    // column keep: x*sw falls in [c*tw, c*tw + tw)
    assign bcol_plus = {1'b0, bcol_reg} + (COL_ACC_W + 1)'(sizes.tw);
    assign col_hit   = ({1'b0, acol_reg} < bcol_plus) && (DIM_W'(x_reg) < sizes.tw);
    assign take      = row_kept_now && col_hit;

    assign pos       = x_reg[1:0];
    assign pack_ins  = pack_reg | (BYTE_W'(gray_level) << {~pos, 1'b0});
    assign x_last    = (DIM_W'(x_reg) == tw_m1);
    assign col_last  = (DIM_W'(col_reg) == sw_m1);
    assign prow_last = (DIM_W'(prow_reg) == sh_m1);
    assign emit      = cmd.step && take && ((pos == 2'd3) || x_last);

    assign ay_init = sizes.top_down ? '0 : prod_reg - ROW_ACC_W'(sizes.sh);
    assign by_init = sizes.top_down ? '0 : prod_reg - ROW_ACC_W'(sizes.th);
    assign y_init  = sizes.top_down ? '0 : ROW_W'(tw_m1 & '0) + ROW_W'(sizes.th - DIM_W'(1));

    always_comb
    begin
        col_next      = col_reg;
        prow_next     = prow_reg;
        x_next        = x_reg;
        acol_next     = acol_reg;
        bcol_next     = bcol_reg;
        ay_next       = ay_reg;
        by_next       = by_reg;
        prod_next     = prod_reg;
        y_next        = y_reg;
        cur_row_next  = cur_row_reg;
        row_kept_next = row_kept_reg;
        pack_next     = pack_reg;

        if (cmd.restart)
        begin
            col_next      = '0;
            prow_next     = '0;
            x_next        = '0;
            acol_next     = '0;
            bcol_next     = '0;
            cur_row_next  = '0;
            row_kept_next = 1'b0;
            pack_next     = '0;
        end
        else if (cmd.mul_en)
        begin
            prod_next = ROW_ACC_W'(sizes.sh) * ROW_ACC_W'(sizes.th);
        end
        else if (cmd.load)
        begin
            ay_next = ay_init;
            by_next = by_init;
            y_next  = y_init;
        end
        else if (cmd.step)
        begin
            if (row_start)
            begin
                row_kept_next = row_hit;
                cur_row_next  = row_hit ? y_reg : '0;
                if (sizes.top_down)
                begin
                    by_next = by_reg + ROW_ACC_W'(sizes.th);
                    if (row_hit)
                    begin
                        ay_next = ay_reg + ROW_ACC_W'(sizes.sh);
                        y_next  = y_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    by_next = by_reg - ROW_ACC_W'(sizes.th);
                    if (row_hit)
                    begin
                        ay_next = ay_reg - ROW_ACC_W'(sizes.sh);
                        y_next  = y_reg - ROW_W'(1);
                    end
                end
            end

            if (take)
            begin
                pack_next = emit ? '0 : pack_ins;
                x_next    = x_reg + XW'(1);
                acol_next = acol_reg + COL_ACC_W'(sizes.sw);
            end

            bcol_next = bcol_reg + COL_ACC_W'(sizes.tw);
            col_next  = col_reg + COL_W'(1);

            if (col_last)
            begin
                col_next  = '0;
                x_next    = '0;
                acol_next = '0;
                bcol_next = '0;
                pack_next = '0;
                prow_next = prow_reg + ROW_W'(1);
                if (prow_last)
                begin
                    // wrap to a new frame
                    prow_next = '0;
                    ay_next   = ay_init;
                    by_next   = by_init;
                    y_next    = y_init;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            prow_reg      <= '0;
            x_reg         <= '0;
            acol_reg      <= '0;
            bcol_reg      <= '0;
            ay_reg        <= '0;
            by_reg        <= '0;
            prod_reg      <= '0;
            y_reg         <= '0;
            cur_row_reg   <= '0;
            row_kept_reg  <= 1'b0;
            pack_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            prow_reg      <= prow_next;
            x_reg         <= x_next;
            acol_reg      <= acol_next;
            bcol_reg      <= bcol_next;
            ay_reg        <= ay_next;
            by_reg        <= by_next;
            prod_reg      <= prod_next;
            y_reg         <= y_next;
            cur_row_reg   <= cur_row_next;
            row_kept_reg  <= row_kept_next;
            pack_reg      <= pack_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= pack_ins;
            out_row_reg  <= TROW_W'(row_now);
            out_bidx_reg <= x_reg[2 +: BIDX_W];
            out_done_reg <= x_last;
        end
    end

    assign stat.out_full = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign packed_byte   = out_byte_reg;
    assign target_row    = out_row_reg;
    assign byte_index    = out_bidx_reg;
    assign row_done      = out_done_reg;

    `ASSERT_ALWAYS(a_col_in_range, DIM_W'(col_reg) < sizes.sw,
                   "source column beyond source width")
    `ASSERT_NEXT(a_pack_cleared, emit, pack_reg == '0,
                 "pack buffer not cleared after a word went out")
    `ASSERT_NEXT(a_row_closed, emit && x_last && !col_last && !cmd.restart,
                 DIM_W'(x_reg) == sizes.tw,
                 "output column did not stop at target width after last word")

endmodule

// ----- rtl/nearest_downscale_2bit_pixels.sv -----
// Top level of the nearest-neighbor downscaler for 2-bit gray pixels.
// Depends on nds_pkg, nds_if, nds_ctrl and nds_dp.

// Takes one 2-bit pixel per word in raster order and emits packed output
// bytes (four pixels, first in bits 7:6, short last byte zero padded) tagged
// with output row, byte index and an end-of-row flag. Throughput is one pixel
// per clock: row and column keep decisions come from add/compare accumulators
// (x*sw against c*tw, y*sh against s*th), so no division sits in the pixel
// path. After reset and every register write the block is not ready in
// ST_MUL, the single 12x12 multiply that sets the starting row accumulators
// for bottom-first frames, or in ST_LOAD, which loads them. While running,
// pixels stall only when a finished byte sits in the output register and the
// sink does not take it that cycle. Any write to a known register index
// restarts the frame; writes to other indexes are ignored. Sizes are clamped
// to 1..2048 columns and 1..3072 rows, and target sizes to the source sizes.
// After the last pixel of a frame the next pixel begins a new frame.

module nearest_downscale_2bit_pixels (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [nds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nds_pkg::DIM_W-1:0]     cfg_data,
    nds_pix_if.sink                       pixels,
    nds_byte_if.source                    results
);
    import nds_pkg::*;

    // configuration registers, raw as written
    logic [DIM_W-1:0] src_w_reg, src_w_next;
    logic [DIM_W-1:0] src_h_reg, src_h_next;
    logic [DIM_W-1:0] tgt_w_reg, tgt_w_next;
    logic [DIM_W-1:0] tgt_h_reg, tgt_h_next;
    logic             top_down_reg, top_down_next;
    logic             cfg_hit;

    nds_sizes_t sizes;
    nds_cmd_t   cmd;
    nds_stat_t  stat;

    // decode the write; an unknown index neither writes nor restarts
    always_comb
    begin
        src_w_next    = src_w_reg;
        src_h_next    = src_h_reg;
        tgt_w_next    = tgt_w_reg;
        tgt_h_next    = tgt_h_reg;
        top_down_next = top_down_reg;
        cfg_hit       = 1'b0;
        if (cfg_we)
        begin
            cfg_hit = cfg_index inside {[CFG_SOURCE_WIDTH:CFG_TOP_DOWN]};
            case (cfg_idx_t'(cfg_index))
                CFG_SOURCE_WIDTH:  src_w_next    = cfg_data;
                CFG_SOURCE_HEIGHT: src_h_next    = cfg_data;
                CFG_TARGET_WIDTH:  tgt_w_next    = cfg_data;
                CFG_TARGET_HEIGHT: tgt_h_next    = cfg_data;
                CFG_TOP_DOWN:      top_down_next = cfg_data[0];
                default:           top_down_next = top_down_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg    <= DIM_W'(MAX_WIDTH);
            src_h_reg    <= DIM_W'(MAX_HEIGHT);
            tgt_w_reg    <= DIM_W'(MAX_WIDTH);
            tgt_h_reg    <= DIM_W'(MAX_HEIGHT);
            top_down_reg <= 1'b0;
        end
        else
        begin
            src_w_reg    <= src_w_next;
            src_h_reg    <= src_h_next;
            tgt_w_reg    <= tgt_w_next;
            tgt_h_reg    <= tgt_h_next;
            top_down_reg <= top_down_next;
        end
    end

    // effective sizes: source to the supported range, target to the source
    always_comb
    begin
        sizes.sw       = clamp_dim(src_w_reg, DIM_W'(MAX_WIDTH));
        sizes.sh       = clamp_dim(src_h_reg, DIM_W'(MAX_HEIGHT));
        sizes.tw       = clamp_dim(tgt_w_reg, sizes.sw);
        sizes.th       = clamp_dim(tgt_h_reg, sizes.sh);
        sizes.top_down = top_down_reg;
    end

    nds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_hit   (cfg_hit),
        .in_valid  (pixels.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .in_ready  (pixels.ready),
        .cmd       (cmd)
    );

    nds_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .sizes       (sizes),
        .cmd         (cmd),
        .stat        (stat),
        .gray_level  (pixels.gray_level),
        .out_ready   (results.ready),
        .out_valid   (results.valid),
        .packed_byte (results.packed_byte),
        .target_row  (results.target_row),
        .byte_index  (results.byte_index),
        .row_done    (results.row_done)
    );

endmodule

// ----- tb/nearest_downscale_2bit_pixels_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for nearest_downscale_2bit_pixels: random and directed
// pixel streams against a cycle-free prediction of the packed output bytes.
// Depends on nds_pkg, nds_if and the RTL top level.

module nearest_downscale_2bit_pixels_tb;

    import nds_pkg::*;

    localparam int QUIET_LIMIT    = 2000;  // cycles with no word moving on either side
    localparam int SETTLE_CYCLES  = 8;     // output register plus the restart setup states
    localparam int PIXEL_TOTAL    = 1950;  // pixel words sent over the whole run
    localparam int FIRST_UNMAPPED = int'(CFG_TOP_DOWN) + 1;

    typedef enum {
        FLOW_FREE,
        SENDER_GAPS,
        SINK_STALLS,
        BOTH_LIGHT
    } flow_mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic [TROW_W-1:0] target_row;
        logic [BIDX_W-1:0] byte_index;
        logic              row_done;
    } out_byte_t;

    // Tracks the frame position, predicts which pixels survive the downscale
    // and holds the bytes they pack into until the block delivers them.
    class byte_stream_tracker;
        logic [DIM_W-1:0]  src_w, src_h, dst_w, dst_h;
        logic              rows_top_first;
        logic [DIM_W-1:0]  phys_row, src_col, next_col, out_row;
        logic              keep_row;
        logic [BYTE_W-1:0] pack;
        out_byte_t         pending_bytes[$];
        int                mismatches;
        int                seen_pixels;

        function new();
            src_w = DIM_W'(MAX_WIDTH);
            src_h = DIM_W'(MAX_HEIGHT);
            dst_w = DIM_W'(MAX_WIDTH);
            dst_h = DIM_W'(MAX_HEIGHT);
            rows_top_first = 1'b0;
            mismatches = 0;
            seen_pixels = 0;
            rewind();
        endfunction

        function void rewind();
            phys_row = '0;
            src_col  = '0;
            next_col = '0;
            out_row  = '0;
            keep_row = 1'b0;
            pack     = '0;
        endfunction

        function int unsigned limit_to(input logic [DIM_W-1:0] v, input int unsigned hi);
            if (v == '0)
                return 1;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
            case (idx)
                CFG_SOURCE_WIDTH:  src_w = val;
                CFG_SOURCE_HEIGHT: src_h = val;
                CFG_TARGET_WIDTH:  dst_w = val;
                CFG_TARGET_HEIGHT: dst_h = val;
                CFG_TOP_DOWN:      rows_top_first = val[0];
                default:           return;
            endcase
            rewind();
        endfunction

        function void take_pixel(input logic [LEVEL_W-1:0] level);
            int unsigned     w, h, tw, th;
            longint unsigned src_y, y, x;
            seen_pixels++;
            w  = limit_to(src_w, MAX_WIDTH);
            h  = limit_to(src_h, MAX_HEIGHT);
            tw = limit_to(dst_w, w);
            th = limit_to(dst_h, h);
            // a shrink can leave the position past the new edge
            if (phys_row >= h)
                phys_row = '0;
            if (src_col >= w)
                src_col = '0;
            // decide the whole row on its first pixel
            if (src_col == '0) begin
                src_y    = rows_top_first ? phys_row : h - 1 - phys_row;
                y        = (src_y * th + h - 1) / h;
                keep_row = (y < th) && ((y * h) / th == src_y);
                out_row  = keep_row ? DIM_W'(y) : '0;
                next_col = '0;
                pack     = '0;
            end
            if (keep_row && next_col < tw) begin
                x = next_col;
                if ((x * w) / tw == src_col) begin
                    pack |= BYTE_W'(level) << (6 - 2 * x[1:0]);
                    if (x[1:0] == 2'd3 || x == tw - 1) begin
                        pending_bytes.push_back('{packed_byte: pack,
                                                  target_row:  out_row,
                                                  byte_index:  x[10:2],
                                                  row_done:    (x == tw - 1)});
                        pack = '0;
                    end
                    next_col++;
                end
            end
            src_col++;
            if (src_col >= w) begin
                src_col = '0;
                phys_row++;
                if (phys_row >= h)
                    phys_row = '0;
            end
        endfunction

        function void report_field(input string name, input int unsigned want,
                                   input int unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_byte(input out_byte_t got);
            out_byte_t want;
            if (pending_bytes.size() == 0) begin
                mismatches++;
                $display("%0t: byte %02h row %0d index %0d done %b expected none, got one",
                         $time, got.packed_byte, got.target_row, got.byte_index, got.row_done);
                return;
            end
            want = pending_bytes.pop_front();
            report_field("packed_byte", want.packed_byte, got.packed_byte);
            report_field("target_row", want.target_row, got.target_row);
            report_field("byte_index", want.byte_index, got.byte_index);
            report_field("row_done", want.row_done, got.row_done);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    nds_pix_if  pix();
    nds_byte_if res();

    byte_stream_tracker tracker = new();
    flow_mode_t         mode = FLOW_FREE;
    int                 quiet_cycles = 0;

    nearest_downscale_2bit_pixels u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix),
        .results   (res)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic bit roll(input int percent);
        return $urandom_range(0, 99) < percent;
    endfunction

    // Percentage of cycles one side holds back under the current flow mode.
    function automatic int hold_pct(input flow_mode_t m, input bit sink_side);
        case (m)
            FLOW_FREE:   return 0;
            SENDER_GAPS: return sink_side ? 0 : 67;
            SINK_STALLS: return sink_side ? 67 : 0;
            default:     return 6;
        endcase
    endfunction

    // Monitor both channels at the edge. The input word is noted before the
    // output word is checked, so even a same-edge pass-through stays ordered.
    // The same block drives the sink's ready and runs the watchdog.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (pix.valid && pix.ready)
                tracker.take_pixel(pix.gray_level);
            if (res.valid && res.ready)
                tracker.check_byte('{packed_byte: res.packed_byte,
                                     target_row:  res.target_row,
                                     byte_index:  res.byte_index,
                                     row_done:    res.row_done});
            if ((pix.valid && pix.ready) || (res.valid && res.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
        res.ready <= !roll(hold_pct(mode, 1'b1));
    end

    // Offer one pixel word, with an optional idle gap first, and hold it until
    // the block takes it. Valid stays high into the next call when no gap
    // follows, so back-to-back words never toggle it within one step.
    task automatic send_pixel(input logic [LEVEL_W-1:0] level);
        if (roll(hold_pct(mode, 1'b0))) begin
            pix.valid <= 1'b0;
            do
                @(posedge clk);
            while (roll(hold_pct(mode, 1'b0)));
        end
        pix.valid      <= 1'b1;
        pix.gray_level <= level;
        do
            @(posedge clk);
        while (!pix.ready);
    endtask

    task automatic feed_random(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(LEVEL_W'($urandom));
    endtask

    // Drop valid, drain every predicted byte, then give the block time to
    // finish any partly packed byte that will never be emitted.
    task automatic settle();
        pix.valid <= 1'b0;
        while (tracker.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all five size registers back to back with the enable held high.
    task automatic apply_sizes(input int w, input int h, input int tw, input int th,
                               input bit top_first);
        cfg_idx_t         regs [5];
        logic [DIM_W-1:0] vals [5];
        regs = '{CFG_SOURCE_WIDTH, CFG_SOURCE_HEIGHT, CFG_TARGET_WIDTH,
                 CFG_TARGET_HEIGHT, CFG_TOP_DOWN};
        vals = '{DIM_W'(w), DIM_W'(h), DIM_W'(tw), DIM_W'(th), DIM_W'(top_first)};
        cfg_we <= 1'b1;
        for (int i = 0; i < 5; i++) begin
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            tracker.write_reg(regs[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // A write to an index with no register behind it must leave the frame alone.
    task automatic write_unmapped();
        logic [CFG_IDX_W-1:0] idx;
        logic [DIM_W-1:0]     val;
        idx = CFG_IDX_W'($urandom_range(FIRST_UNMAPPED, 2**CFG_IDX_W - 1));
        val = DIM_W'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.write_reg(idx, val);
    endtask

    // One setting of the sizes, a stream of random pixels, and optionally an
    // unmapped write halfway through that the stream must run straight past.
    task automatic run_phase(input int w, input int h, input int tw, input int th,
                             input bit top_first, input int count, input bit poke);
        apply_sizes(w, h, tw, th, top_first);
        if (poke) begin
            feed_random(count / 2);
            settle();
            write_unmapped();
            feed_random(count - count / 2);
        end
        else begin
            feed_random(count);
        end
        settle();
    endtask

    initial
    begin
        int w, h, tw, th, frame_pixels, count, phase_no;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        pix.valid      <= 1'b0;
        pix.gray_level <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a 5x3 frame down to 3x2, rows top first, so both rows and
        // columns get dropped; run past the frame end to see the wrap, then
        // poke an unmapped index and carry on from the same position.
        mode = FLOW_FREE;
        apply_sizes(5, 3, 3, 2, 1'b1);
        for (int i = 0; i < 17; i++)
            send_pixel(LEVEL_W'(i));
        settle();
        write_unmapped();
        for (int i = 0; i < 2; i++)
            send_pixel(LEVEL_W'(3 - i));
        settle();

        // Zero sizes clamp to one pixel, oversized targets saturate to it:
        // every pixel becomes a lone byte that also closes its row.
        mode = BOTH_LIGHT;
        apply_sizes(0, 0, 4095, 4095, 1'b0);
        for (int i = 0; i < 4; i++)
            send_pixel(LEVEL_W'(i ^ 3));
        settle();

        // Extremes: a long stretch of the widest row, the tallest frame
        // bottom first (bottom output rows), full-size partial row.
        mode = SINK_STALLS;
        run_phase(4095, 1, 2048, 1, 1'b1, 600, 1'b0);
        mode = SENDER_GAPS;
        run_phase(1, 3072, 1, 3072, 1'b0, 200, 1'b0);
        mode = FLOW_FREE;
        run_phase(2048, 3072, 4095, 4095, 1'b1, 200, 1'b1);
        mode = BOTH_LIGHT;
        run_phase(3, 4095, 2, 1536, 1'b1, 150, 1'b0);

        // Random small frames, mostly streamed past their end, cycling
        // through the flow modes until the pixel budget is spent.
        phase_no = 0;
        while (tracker.seen_pixels < PIXEL_TOTAL) begin
            w = roll(25) ? $urandom_range(25, 96) : $urandom_range(1, 24);
            h = $urandom_range(1, 8);
            tw = roll(20) ? $urandom_range(0, w + 8) : $urandom_range((w + 1) / 2, w);
            th = roll(20) ? $urandom_range(0, h + 4) : $urandom_range(1, h);
            if (roll(5))
                w = 0;
            if (roll(5))
                h = 0;
            frame_pixels = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
            count = frame_pixels + $urandom_range(0, frame_pixels);
            if (count > PIXEL_TOTAL - tracker.seen_pixels)
                count = PIXEL_TOTAL - tracker.seen_pixels;
            mode = flow_mode_t'(phase_no % 4);
            run_phase(w, h, tw, th, 1'($urandom), count, roll(25));
            phase_no++;
        end

        if (tracker.mismatches == 0 && tracker.pending_bytes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/nds_pkg.sv
rtl/nds_if.sv
rtl/nds_ctrl.sv
rtl/nds_dp.sv
rtl/nearest_downscale_2bit_pixels.sv
tb/nearest_downscale_2bit_pixels_tb.sv
